@@ rtl/assert_macros.svh @@
// Assertion macros shared by the register file RTL.
// Each macro expands to one labeled concurrent assertion on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SBRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every edge, during reset too.
`define SBRF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/sbrf_pkg.sv @@
// Package of the sensor bridge register file: address map, codes and types.
// Used by sbrf_decode and the top level; no dependencies.
package sbrf_pkg;

    localparam int CORE_WINDOW_DEPTH = 16384;

    localparam logic [31:0] CORE_BASE      = 32'h3000_0000;
    localparam logic [31:0] CTRL_BASE      = 32'h7000_0000;
    localparam logic [31:0] USER_CTRL_ADDR = 32'h7000_0000;
    localparam logic [31:0] TYPE_CTRL_ADDR = 32'h7000_0004;
    localparam logic [31:0] STATUS_ADDR    = 32'h7000_0008;
    localparam logic [31:0] CTRL_END_ADDR  = 32'h7000_0018;
    localparam logic [31:0] GPIO_OUT_ADDR  = 32'h0000_000C;
    localparam logic [31:0] GPIO_DIR_ADDR  = 32'h0000_002C;
    localparam logic [31:0] GPIO_STAT_ADDR = 32'h0000_008C;

    localparam int CTRL_DEPTH      = 24;
    localparam int GPIO_WORD_BYTES = 4;
    localparam int GPIO_DEPTH      = 3 * GPIO_WORD_BYTES;
    // control block and GPIO entries sit above the core window in the RAM
    localparam int SMALL_DEPTH     = CTRL_DEPTH + GPIO_DEPTH;

    localparam int STATUS_CLEAR_BIT = 0;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef struct packed {
        logic hit;
        logic read_only;   // status word or GPIO status word
        logic user_ctrl;
        logic type_ctrl;
        logic status;
    } t_dec;

endpackage

@@ rtl/sbrf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sbrf_decode.sv @@
// Address decoder: maps a byte address to a RAM entry and flags side effects.
// Depends on sbrf_pkg.
module sbrf_decode import sbrf_pkg::*; #(
    parameter int CORE_DEPTH = CORE_WINDOW_DEPTH,
    parameter int AW         = $clog2(CORE_DEPTH + SMALL_DEPTH)
) (
    input  logic [31:0]   i_address,
    output t_dec          o_dec,
    output logic [AW-1:0] o_index
);

    localparam int CTRL_IDX     = CORE_DEPTH;
    localparam int GPIO_OUT_IDX = CORE_DEPTH + CTRL_DEPTH;
    localparam int GPIO_DIR_IDX = GPIO_OUT_IDX + GPIO_WORD_BYTES;
    localparam int GPIO_ST_IDX  = GPIO_DIR_IDX + GPIO_WORD_BYTES;

    logic [31:0] core_off;
    logic [31:0] ctrl_off;
    logic        in_core;
    logic        in_ctrl;
    logic        in_gout;
    logic        in_gdir;
    logic        in_gstat;
    logic        gstat_word;

    always_comb begin
        core_off   = i_address - CORE_BASE;
        ctrl_off   = i_address - CTRL_BASE;
        in_core    = (i_address >= CORE_BASE) && (core_off < 32'(CORE_DEPTH));
        in_ctrl    = (i_address >= CTRL_BASE) && (i_address < CTRL_END_ADDR);
        in_gout    = (i_address[31:2] == GPIO_OUT_ADDR[31:2]);
        in_gdir    = (i_address[31:2] == GPIO_DIR_ADDR[31:2]);
        in_gstat   = (i_address[31:2] == GPIO_STAT_ADDR[31:2]);
        gstat_word = (i_address == GPIO_STAT_ADDR);

        o_dec.hit       = in_core || in_ctrl || in_gout || in_gdir || in_gstat;
        o_dec.status    = (i_address == STATUS_ADDR);
        o_dec.read_only = o_dec.status || gstat_word;
        o_dec.user_ctrl = (i_address == USER_CTRL_ADDR);
        o_dec.type_ctrl = (i_address == TYPE_CTRL_ADDR);

        o_index = '0;
        if (in_core) begin
            o_index = core_off[AW-1:0];
        end else if (in_ctrl) begin
            o_index = AW'(CTRL_IDX) + AW'(ctrl_off[4:0]);
        end else if (in_gout || gstat_word) begin
            // a GPIO status word read returns the GPIO output word
            o_index = AW'(GPIO_OUT_IDX) + (gstat_word ? AW'(0) : AW'(i_address[1:0]));
        end else if (in_gdir) begin
            o_index = AW'(GPIO_DIR_IDX) + AW'(i_address[1:0]);
        end else if (in_gstat) begin
            o_index = AW'(GPIO_ST_IDX) + AW'(i_address[1:0]);
        end
    end

endmodule

@@ rtl/sensor_bridge_register_file_core.sv @@
// Top level of the sensor bridge register file: sequencer, status word, output register.
// Depends on sbrf_pkg, sbrf_decode, sbrf_ram and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one bus access per word:
//   i_kind (0 read, 1 write), i_address, i_write_data. The output channel
//   (o_out_valid / i_out_ready) returns one word per access: o_hit and
//   o_read_data (0 for writes and misses).
//   Results: writes and misses show their result in the cycle after acceptance,
//   reads after the registered read of the shared RAM and then the output register.
//   Throughput: one write or miss per cycle unless the output stalls; none in ST_READ.
//   All windows live in one RAM of CORE_DEPTH + 36 entries; the status word
//   is a register of its own.
//   Reset: a clearing pass writes zero to every RAM entry; o_in_ready stays low.
//   Stall: a result waits in the output register while i_out_ready is low; a
//   new access is taken in the same cycle the waiting result is taken.
`include "assert_macros.svh"

module sensor_bridge_register_file_core import sbrf_pkg::*; #(
    parameter int CORE_DEPTH = CORE_WINDOW_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic [31:0] o_read_data
);

    localparam int RAM_DEPTH = CORE_DEPTH + SMALL_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [31:0]   r_status, n_status;
    logic          r_out_valid, n_out_valid;
    logic          r_out_hit, n_out_hit;
    logic [31:0]   r_out_data, n_out_data;
    logic          r_rd_status, n_rd_status;

    t_dec          dec;
    logic [AW-1:0] dec_index;
    logic          in_acc;
    logic          is_wr;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [31:0]   ram_rdata;

    sbrf_decode #(
        .CORE_DEPTH (CORE_DEPTH),
        .AW         (AW)
    ) u_decode (
        .i_address (i_address),
        .o_dec     (dec),
        .o_index   (dec_index)
    );

    sbrf_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (dec_index),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_wr      = (i_kind == KIND_WRITE);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = in_acc && is_wr && dec.hit && !dec.read_only;
            ram_waddr = dec_index;
            ram_wdata = i_write_data;
        end
        ram_re = in_acc && !is_wr && dec.hit;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_data  = r_out_data;
        n_rd_status = r_rd_status;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(RAM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    if (!is_wr && dec.hit) begin
                        n_state     = ST_READ;
                        n_rd_status = dec.status;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_hit   = dec.hit;
                        n_out_data  = '0;
                    end
                    if (is_wr && dec.user_ctrl && i_write_data[STATUS_CLEAR_BIT]) begin
                        n_status = '0;
                    end else if (is_wr && dec.type_ctrl) begin
                        n_status = i_write_data;
                    end
                end
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_hit   = 1'b1;
                n_out_data  = r_rd_status ? r_status : ram_rdata;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_status    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
        r_out_hit   <= n_out_hit;
        r_out_data  <= n_out_data;
        r_rd_status <= n_rd_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_read_data = r_out_data;

    `SBRF_ASSERT(a_read_delivers, (r_state == ST_READ) |=> o_out_valid && o_hit, "read did not deliver a hit word")
    `SBRF_ASSERT(a_miss_zero, (o_out_valid && !o_hit) |-> (o_read_data == 32'd0), "miss returned nonzero data")
    `SBRF_ASSERT(a_accept_progress, (i_in_valid && o_in_ready) |=> (r_state == ST_READ) || o_out_valid, "accepted word produced no result")
    `SBRF_ASSERT_ALWAYS(a_no_accept_in_clear, (r_state == ST_CLEAR) |-> !o_in_ready, "word accepted during clearing pass")

endmodule

@@ tb/tb_sensor_bridge_register_file_core.sv @@
// Self-checking testbench for sensor_bridge_register_file_core: bus accesses in, hit/read words out.
// A software copy of the register map predicts every word; needs sbrf_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_sensor_bridge_register_file_core;
    import sbrf_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [31:0] data;
        logic        drain_first;   // hold this access until every result is back
    } t_access;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
    } t_bus_word;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_kind       = KIND_READ;
    logic [31:0] i_address    = '0;
    logic [31:0] i_write_data = '0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_hit;
    logic [31:0] o_read_data;

    // shadow copy of the register map
    logic [31:0] core_words [CORE_WINDOW_DEPTH];
    logic [31:0] ctrl_words [CTRL_DEPTH];
    logic [31:0] gpio_words [GPIO_DEPTH];

    t_access   access_queue [$];
    t_bus_word expected_words [$];

    int items_taken   = 0;   // both counters advance by NBA so readers see pre-edge values
    int results_taken = 0;
    int total_items   = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    logic hold_done   = 1'b0;

    sensor_bridge_register_file_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_read_data  (o_read_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one access to the shadow map and returns the word the block should give back.
    function automatic void predict_access(input logic kind, input logic [31:0] addr,
                                           input logic [31:0] data, output logic hit,
                                           output logic [31:0] rd);
        logic [31:0] off_core;
        logic [31:0] off_ctrl;
        logic [31:0] off_out;
        logic [31:0] off_dir;
        logic [31:0] off_stat;
        off_core = addr - CORE_BASE;
        off_ctrl = addr - CTRL_BASE;
        off_out  = addr - GPIO_OUT_ADDR;
        off_dir  = addr - GPIO_DIR_ADDR;
        off_stat = addr - GPIO_STAT_ADDR;
        hit = 1'b1;
        rd  = '0;
        if (addr >= CORE_BASE && off_core < CORE_WINDOW_DEPTH) begin
            if (kind == KIND_WRITE) core_words[off_core] = data;
            else rd = core_words[off_core];
        end else if (addr >= CTRL_BASE && off_ctrl < CTRL_DEPTH) begin
            if (kind == KIND_READ) begin
                rd = ctrl_words[off_ctrl];
            end else if (addr == USER_CTRL_ADDR) begin
                if (data[STATUS_CLEAR_BIT]) ctrl_words[STATUS_ADDR - CTRL_BASE] = '0;
                ctrl_words[off_ctrl] = data;
            end else if (addr != STATUS_ADDR) begin
                if (addr == TYPE_CTRL_ADDR) ctrl_words[STATUS_ADDR - CTRL_BASE] = data;
                ctrl_words[off_ctrl] = data;
            end
        end else if (addr >= GPIO_OUT_ADDR && off_out < GPIO_WORD_BYTES) begin
            if (kind == KIND_WRITE) gpio_words[off_out] = data;
            else rd = gpio_words[off_out];
        end else if (addr >= GPIO_DIR_ADDR && off_dir < GPIO_WORD_BYTES) begin
            if (kind == KIND_WRITE) gpio_words[GPIO_WORD_BYTES + off_dir] = data;
            else rd = gpio_words[GPIO_WORD_BYTES + off_dir];
        end else if (addr >= GPIO_STAT_ADDR && off_stat < GPIO_WORD_BYTES) begin
            // status word mirrors the output word and ignores writes; other bytes store
            if (kind == KIND_READ) begin
                rd = (addr == GPIO_STAT_ADDR) ? gpio_words[0]
                                              : gpio_words[2 * GPIO_WORD_BYTES + off_stat];
            end else if (addr != GPIO_STAT_ADDR) begin
                gpio_words[2 * GPIO_WORD_BYTES + off_stat] = data;
            end
        end else begin
            hit = 1'b0;
        end
    endfunction

    task automatic queue_access(input logic kind, input logic [31:0] addr,
                                input logic [31:0] data, input logic drain_first = 1'b0);
        access_queue.push_back('{kind, addr, data, drain_first});
    endtask

    task automatic note_failure(input string what);
        if (fail_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    // sender
    always @(posedge i_clk) begin
        logic        taken;
        logic        offer;
        logic        calm;
        logic        hit_p;
        logic [31:0] rd_p;
        taken = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer = i_in_valid;
            calm  = (items_taken >= 800 && items_taken < 1100);
            if (i_in_valid && o_in_ready) begin
                predict_access(i_kind, i_address, i_write_data, hit_p, rd_p);
                expected_words.push_back('{hit_p, rd_p});
                void'(access_queue.pop_front());
                items_taken <= items_taken + 1;
                taken = 1'b1;
                offer = 1'b0;
            end
            if (!offer && access_queue.size() > 0 && (calm || $urandom_range(99) >= 26)
                && (!access_queue[0].drain_first || items_taken + taken == results_taken)) begin
                offer = 1'b1;
                i_kind       <= access_queue[0].kind;
                i_address    <= access_queue[0].addr;
                i_write_data <= access_queue[0].data;
            end
            i_in_valid <= offer;
        end
    end

    // receiver: random stalls, one long hold-off, a calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && results_taken >= 300) begin
            i_out_ready <= 1'b0;
            hold_left   <= 400;
            hold_done   <= 1'b1;
        end else begin
            i_out_ready <= (results_taken >= 800 && results_taken < 1100)
                           || $urandom_range(99) >= 26;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_bus_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_taken <= results_taken + 1;
            if (results_taken >= items_taken) begin
                note_failure($sformatf("word with no access pending: hit %b data %h",
                                       o_hit, o_read_data));
            end else begin
                want = expected_words.pop_front();
                if (o_hit !== want.hit)
                    note_failure($sformatf("word %0d hit: expected %b, got %b",
                                           results_taken, want.hit, o_hit));
                if (o_read_data !== want.read_data)
                    note_failure($sformatf("word %0d read_data: expected %h, got %h",
                                           results_taken, want.read_data, o_read_data));
            end
        end
    end

    initial begin
        logic [31:0] addr;
        logic [31:0] gpio_base;
        foreach (core_words[k]) core_words[k] = '0;
        foreach (ctrl_words[k]) ctrl_words[k] = '0;
        foreach (gpio_words[k]) gpio_words[k] = '0;

        // window edges, side effects, read-only words
        queue_access(KIND_READ,  CORE_BASE, '0);
        queue_access(KIND_WRITE, CORE_BASE, 32'hFFFF_FFFF);
        queue_access(KIND_READ,  CORE_BASE, '0);
        queue_access(KIND_WRITE, CORE_BASE + CORE_WINDOW_DEPTH - 1, 32'h8000_0001);
        queue_access(KIND_READ,  CORE_BASE + CORE_WINDOW_DEPTH - 1, 32'hFFFF_FFFF);
        queue_access(KIND_WRITE, CORE_BASE + CORE_WINDOW_DEPTH, 32'h0000_0001);
        queue_access(KIND_READ,  CORE_BASE - 1, '0);
        queue_access(KIND_WRITE, TYPE_CTRL_ADDR, 32'hA5A5_5A5A);
        queue_access(KIND_READ,  STATUS_ADDR, '0);
        queue_access(KIND_WRITE, STATUS_ADDR, '0);
        queue_access(KIND_READ,  STATUS_ADDR, '0);
        queue_access(KIND_WRITE, USER_CTRL_ADDR, 32'h0000_0002);
        queue_access(KIND_READ,  STATUS_ADDR, '0);
        queue_access(KIND_WRITE, USER_CTRL_ADDR, 32'hFFFF_FFFF);
        queue_access(KIND_READ,  STATUS_ADDR, '0);
        queue_access(KIND_READ,  USER_CTRL_ADDR, '0);
        queue_access(KIND_READ,  CTRL_END_ADDR - 1, '0);
        queue_access(KIND_WRITE, CTRL_END_ADDR, 32'h1234_0000);
        queue_access(KIND_WRITE, GPIO_OUT_ADDR, 32'h1234_5678);
        queue_access(KIND_READ,  GPIO_STAT_ADDR, '0);
        queue_access(KIND_WRITE, GPIO_STAT_ADDR, '0);
        queue_access(KIND_READ,  GPIO_STAT_ADDR, '0);
        queue_access(KIND_WRITE, GPIO_STAT_ADDR + 1, 32'hDEAD_BEEF);
        queue_access(KIND_READ,  GPIO_STAT_ADDR + 1, '0);
        queue_access(KIND_WRITE, GPIO_DIR_ADDR + 3, 32'h0F0F_00FF);
        queue_access(KIND_READ,  GPIO_DIR_ADDR + 3, '0);
        queue_access(KIND_READ,  GPIO_OUT_ADDR - 1, '0);
        queue_access(KIND_READ,  32'hFFFF_FFFF, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ($urandom_range(2))
                0:       gpio_base = GPIO_OUT_ADDR;
                1:       gpio_base = GPIO_DIR_ADDR;
                default: gpio_base = GPIO_STAT_ADDR;
            endcase
            // mostly a small hot set so reads find earlier writes
            addr = $urandom_range(99);
            if (addr < 30)      addr = CORE_BASE + $urandom_range(47);
            else if (addr < 38) addr = CORE_BASE + $urandom_range(CORE_WINDOW_DEPTH - 1);
            else if (addr < 42) addr = CORE_BASE + CORE_WINDOW_DEPTH - 4 + $urandom_range(7);
            else if (addr < 62) addr = CTRL_BASE + $urandom_range(CTRL_DEPTH + 3);
            else if (addr < 70) addr = CTRL_BASE + 4 * $urandom_range(2);
            else if (addr < 85) addr = gpio_base - 1 + $urandom_range(GPIO_WORD_BYTES + 1);
            else if (addr < 90) addr = $urandom_range(255);
            else                addr = $urandom();
            queue_access($urandom_range(1), addr, $urandom(), n == 500 || n == 1100);
        end
        total_items = access_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (items_taken != total_items || results_taken != total_items);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("sensor_bridge_register_file_core regression: pass");
        end else begin
            $display("sensor_bridge_register_file_core regression: fail");
        end
        $finish;
    end

    // covers the reset clearing pass plus a slow, heavily stalled run
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sensor_bridge_register_file_core regression: fail");
        $finish;
    end

endmodule

@@ sensor_bridge_register_file_core.f @@
+incdir+rtl
rtl/sbrf_pkg.sv
rtl/sbrf_ram.sv
rtl/sbrf_decode.sv
rtl/sensor_bridge_register_file_core.sv
tb/tb_sensor_bridge_register_file_core.sv
